// File: hw/rtl/magnetometer_heading_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the magnetometer heading unit
// Shorthand for clocked implications on clock, with reset handling.
// ---------------------------------------------------------------------------
`ifndef MAGNETOMETER_HEADING_UNIT_MACROS_SVH
`define MAGNETOMETER_HEADING_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define MHD_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mhd assertion failed");

// next-cycle implication, off during reset
`define MHD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mhd assertion failed");

// next-cycle implication, checked through reset as well
`define MHD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("mhd assertion failed");

`endif

// File: hw/rtl/mhd_pkg.sv
// ---------------------------------------------------------------------------
// mhd_pkg
// Types, constants and helper functions shared by the heading unit modules.
// ---------------------------------------------------------------------------
package mhd_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int STAGE_W       = 5;
   localparam int FRAC          = 16;
   localparam int VEC_W         = 36;
   localparam int Z_W           = 30;
   localparam int HDG_W         = 12;
   localparam int IN_W          = 48;
   localparam int OUT_W         = 80;

   // headings in tenths of a degree
   localparam logic [HDG_W-1:0] HDG_QUARTER = 12'd900;
   localparam logic [HDG_W-1:0] HDG_HALF    = 12'd1800;
   localparam logic [HDG_W-1:0] HDG_THREE_Q = 12'd2700;
   localparam logic [HDG_W-1:0] HDG_FULL    = 12'd3600;

   // the same angles in accumulator units
   localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(longint'(900) << FRAC);
   localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(longint'(1800) << FRAC);
   localparam logic signed [Z_W-1:0] Z_FULL    = Z_W'(longint'(3600) << FRAC);

   typedef struct packed {
      logic signed [15:0]      field_x;
      logic signed [15:0]      field_y;
      logic signed [15:0]      field_z;
      logic                    fixed;
      logic [HDG_W-1:0]        fixed_heading;
      logic signed [VEC_W-1:0] vx;
      logic signed [VEC_W-1:0] vy;
      logic signed [Z_W-1:0]   z;
   } mhd_item_type;

   // atan(2^-s) in 2^-16 tenths of a degree, rounded
   function automatic logic signed [Z_W-1:0] atan_angle(input logic [STAGE_W-1:0] s);
      logic signed [Z_W-1:0] a;
      case (s)
         5'd0:    a = Z_W'(29491200);
         5'd1:    a = Z_W'(17409672);
         5'd2:    a = Z_W'(9198793);
         5'd3:    a = Z_W'(4669451);
         5'd4:    a = Z_W'(2343786);
         5'd5:    a = Z_W'(1173036);
         5'd6:    a = Z_W'(586661);
         5'd7:    a = Z_W'(293348);
         5'd8:    a = Z_W'(146676);
         5'd9:    a = Z_W'(73339);
         5'd10:   a = Z_W'(36669);
         5'd11:   a = Z_W'(18335);
         5'd12:   a = Z_W'(9167);
         5'd13:   a = Z_W'(4584);
         5'd14:   a = Z_W'(2292);
         5'd15:   a = Z_W'(1146);
         5'd16:   a = Z_W'(573);
         5'd17:   a = Z_W'(286);
         5'd18:   a = Z_W'(143);
         5'd19:   a = Z_W'(72);
         5'd20:   a = Z_W'(36);
         5'd21:   a = Z_W'(18);
         5'd22:   a = Z_W'(9);
         5'd23:   a = Z_W'(4);
         default: a = '0;
      endcase
      return a;
   endfunction

   // reciprocal multiplies, exact for inputs below 4096
   function automatic logic [8:0] div10(input logic [HDG_W-1:0] t);
      logic [23:0] p;
      p = 24'(t) * 24'd3277;
      return p[23:15];
   endfunction

   function automatic logic [5:0] div100(input logic [HDG_W-1:0] t);
      logic [24:0] p;
      p = 25'(t) * 25'd5243;
      return p[24:19];
   endfunction

   function automatic logic [2:0] div1000(input logic [HDG_W-1:0] t);
      logic [24:0] p;
      p = 25'(t) * 25'd4195;
      return p[24:22];
   endfunction

endpackage

// File: hw/rtl/mhd_front.sv
// ---------------------------------------------------------------------------
// mhd_front
// Assembles the axis words, flags the on-axis cases and pre-rotates the
// left half plane into the right one before the rotation cells.
// ---------------------------------------------------------------------------
module mhd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [mhd_pkg::IN_W-1:0]  in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output mhd_pkg::mhd_item_type     out_item
);
   import mhd_pkg::*;

   logic                    valid_ff;
   mhd_item_type            item_ff;
   mhd_item_type            item_in;
   logic signed [15:0]      x;
   logic signed [15:0]      y;
   logic signed [VEC_W-1:0] vx;
   logic signed [VEC_W-1:0] vy;

   assign x  = {in_data[7:0], in_data[15:8]};
   assign y  = {in_data[39:32], in_data[47:40]};
   assign vx = {{(VEC_W-16-FRAC){x[15]}}, x, {FRAC{1'b0}}};
   assign vy = {{(VEC_W-16-FRAC){y[15]}}, y, {FRAC{1'b0}}};

   always_comb begin
      item_in               = '0;
      item_in.field_x       = x;
      item_in.field_y       = y;
      item_in.field_z       = {in_data[23:16], in_data[31:24]};
      item_in.vx            = vx;
      item_in.vy            = vy;
      item_in.z             = '0;
      if (y == 16'sd0) begin
         item_in.fixed         = 1'b1;
         item_in.fixed_heading = x[15] ? HDG_FULL : HDG_HALF;
      end else if (x == 16'sd0) begin
         item_in.fixed         = 1'b1;
         item_in.fixed_heading = y[15] ? HDG_QUARTER : HDG_THREE_Q;
      end else if (x[15]) begin
         // rotate a quarter turn into the right half plane
         if (!y[15]) begin
            item_in.vx = vy;
            item_in.vy = -vx;
            item_in.z  = Z_QUARTER;
         end else begin
            item_in.vx = -vy;
            item_in.vy = vx;
            item_in.z  = -Z_QUARTER;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: hw/rtl/mhd_cell.sv
// ---------------------------------------------------------------------------
// mhd_cell
// One vectoring rotation step: drives the vector toward the positive X axis
// and accumulates the angle turned, then hands the item to the next cell.
// ---------------------------------------------------------------------------
module mhd_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [mhd_pkg::STAGE_W-1:0]  stage,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  mhd_pkg::mhd_item_type        in_item,
   output logic                         out_valid,
   input  logic                         out_ready,
   output mhd_pkg::mhd_item_type        out_item
);
   import mhd_pkg::*;

   logic                    valid_ff;
   mhd_item_type            item_ff;
   mhd_item_type            item_in;
   logic signed [VEC_W-1:0] dx;
   logic signed [VEC_W-1:0] dy;
   logic signed [Z_W-1:0]   angle;

   // arithmetic shift rounds toward minus infinity
   assign dx    = in_item.vy >>> stage;
   assign dy    = in_item.vx >>> stage;
   assign angle = atan_angle(stage);

   always_comb begin
      item_in = in_item;
      if (!in_item.vy[VEC_W-1]) begin
         item_in.vx = in_item.vx + dx;
         item_in.vy = in_item.vy - dy;
         item_in.z  = in_item.z + angle;
      end else begin
         item_in.vx = in_item.vx - dx;
         item_in.vy = in_item.vy + dy;
         item_in.z  = in_item.z - angle;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: hw/rtl/mhd_back.sv
// ---------------------------------------------------------------------------
// mhd_back
// Offsets and clamps the accumulated angle to a 0..3600 heading, holds the
// result item and splits the heading into decimal digits.
// ---------------------------------------------------------------------------
module mhd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  mhd_pkg::mhd_item_type     in_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [mhd_pkg::OUT_W-1:0] out_data
);
   import mhd_pkg::*;

   logic                  valid_ff;
   logic [47:0]           fields_ff;
   logic [HDG_W-1:0]      heading_ff;
   logic [HDG_W-1:0]      heading_in;
   logic signed [Z_W-1:0] h;
   logic [8:0]            q10;
   logic [5:0]            q100;
   logic [2:0]            q1000;
   logic [HDG_W-1:0]      tenth_wide;
   logic [8:0]            units_wide;
   logic [5:0]            tens_wide;

   assign h = in_item.z + Z_HALF;

   always_comb begin
      if (in_item.fixed) begin
         heading_in = in_item.fixed_heading;
      end else if (h[Z_W-1]) begin
         heading_in = '0;
      end else if (h > Z_FULL) begin
         heading_in = HDG_FULL;
      end else begin
         heading_in = h[FRAC+HDG_W-1:FRAC];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         fields_ff  <= {in_item.field_z, in_item.field_y, in_item.field_x};
         heading_ff <= heading_in;
      end
   end

   assign q10        = div10(heading_ff);
   assign q100       = div100(heading_ff);
   assign q1000      = div1000(heading_ff);
   assign tenth_wide = heading_ff - (12'(q10) * 12'd10);
   assign units_wide = q10 - (9'(q100) * 9'd10);
   assign tens_wide  = q100 - (6'(q1000) * 6'd10);

   assign out_valid = valid_ff;
   assign out_data  = {6'b0, tenth_wide[3:0], units_wide[3:0], tens_wide[3:0],
                       q1000[1:0], heading_ff, fields_ff};

endmodule

// File: hw/rtl/magnetometer_heading_unit.sv
// ---------------------------------------------------------------------------
// magnetometer_heading_unit
// Compass heading and digits from the six raw magnetometer data bytes.
// ---------------------------------------------------------------------------
// The unit takes one item per cycle and returns one result item per input
// item, in order. Each item passes through a chain of registered stages:
// one to assemble and pre-rotate, one per rotation cell (16 stages), one to
// clamp the heading. Every stage holds its own item and moves on when the
// stage after it has room, so the input side keeps taking items while a
// result waits on the output; the unit stops taking items only once every
// stage is full.
module magnetometer_heading_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // x_high_byte, x_low_byte, z_high_byte, z_low_byte, y_high_byte, y_low_byte
   input  logic [mhd_pkg::IN_W-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // field_x, field_y, field_z, heading_tenths, heading_digit_hundreds,
   // heading_digit_tens, heading_digit_units, heading_digit_tenth, zero pad
   output logic [mhd_pkg::OUT_W-1:0]  rsp_tdata
);
   import mhd_pkg::*;

   mhd_item_type chain_item  [CORDIC_STAGES+1];
   logic         chain_valid [CORDIC_STAGES+1];
   logic         chain_ready [CORDIC_STAGES+1];

   mhd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_item  (chain_item[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      mhd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage     (STAGE_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   mhd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_ready  (chain_ready[CORDIC_STAGES]),
      .in_item   (chain_item[CORDIC_STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

// File: hw/rtl/mhd_checker.sv
// ---------------------------------------------------------------------------
// mhd_checker
// Port-level checks for the heading unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "magnetometer_heading_unit_macros.svh"

module mhd_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [mhd_pkg::IN_W-1:0]   req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [mhd_pkg::OUT_W-1:0]  rsp_tdata
);
   import mhd_pkg::*;

   logic [HDG_W-1:0] heading;
   logic [15:0]      digit_sum;

   assign heading   = rsp_tdata[59:48];
   assign digit_sum = 16'(rsp_tdata[61:60]) * 16'd1000 + 16'(rsp_tdata[65:62]) * 16'd100
                    + 16'(rsp_tdata[69:66]) * 16'd10 + 16'(rsp_tdata[73:70]);

   `MHD_ASSERT_NEXT_ALWAYS(a_reset_empties, reset, !rsp_tvalid)
   `MHD_ASSERT_NEXT(a_rsp_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `MHD_ASSERT_IMPLY(a_heading_range, rsp_tvalid, heading <= HDG_FULL)
   `MHD_ASSERT_IMPLY(a_digits_match, rsp_tvalid, digit_sum == 16'(heading))
   // an empty or draining output frees every stage behind it
   `MHD_ASSERT_IMPLY(a_ready_when_drained, !rsp_tvalid || rsp_tready, req_tready)

endmodule

bind magnetometer_heading_unit mhd_checker u_checker (.*);
